// ----- hw/rtl/bit_field_deposit_extract_unit_macros.svh -----
// Assertion macros for the bit-field deposit/extract unit.
// Included by the top level, which carries the concurrent checks; expects clk and rst in scope.
`ifndef BIT_FIELD_DEPOSIT_EXTRACT_UNIT_MACROS_SVH
`define BIT_FIELD_DEPOSIT_EXTRACT_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BFDEU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define BFDEU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bfdeu_pkg.sv -----
// Shared types and constants for the bit-field deposit/extract unit.
// No dependencies; used by bfdeu_exec, the top level and the testbench.
package bfdeu_pkg;

  // Operation codes; the remaining codes are undefined and fault
  typedef enum logic [2:0] {
    OP_DEP_REG  = 3'd0,
    OP_EXTR_U   = 3'd1,
    OP_DEP_IMM1 = 3'd2,
    OP_ZDEP_IMM = 3'd3,
    OP_TBIT_Z   = 3'd4
  } opcode_t;

  localparam int unsigned IMM_W  = 8;
  localparam int unsigned DEST_W = 7;

  // Write and status flags of one result item
  typedef struct packed {
    logic result_nat;
    logic write_register;
    logic pred_first;
    logic pred_second;
    logic write_predicates;
    logic illegal_fault;
  } flags_t;

endpackage

// ----- hw/rtl/bit_field_deposit_extract_unit.sv -----
// Top level of the bit-field deposit/extract unit: input register, datapath, result register.
// Depends on bfdeu_pkg, bfdeu_exec and bit_field_deposit_extract_unit_macros.svh.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   in      | to unit   | in_valid / in_stall  | opcode .. pred_targets_equal
//   out     | from unit | out_valid / out_stall| result_value .. illegal_fault
//
// One item per cycle unless out_stall holds; out_valid rises as the result register loads.
// The item sits in the input register, crosses the shift/mask datapath, and lands
// in the result register. rst clears both valid bits; payload registers are not reset.
// out_stall holds the result register and, once the input register is also full,
// raises in_stall in the same cycle.
module bit_field_deposit_extract_unit #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      opcode,
  input  logic                            qualifying_predicate,
  input  logic [DATA_WIDTH-1:0]           source_a,
  input  logic                            source_a_nat,
  input  logic [DATA_WIDTH-1:0]           source_b,
  input  logic                            source_b_nat,
  input  logic [$clog2(DATA_WIDTH)-1:0]   bit_position,
  input  logic [$clog2(DATA_WIDTH):0]     field_length,
  input  logic [bfdeu_pkg::IMM_W-1:0]     immediate,
  input  logic [bfdeu_pkg::DEST_W-1:0]    dest_index,
  input  logic                            pred_targets_equal,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [DATA_WIDTH-1:0]           result_value,
  output logic                            result_nat,
  output logic                            write_register,
  output logic [bfdeu_pkg::DEST_W-1:0]    write_index,
  output logic                            pred_first,
  output logic                            pred_second,
  output logic                            write_predicates,
  output logic                            illegal_fault
);
  import bfdeu_pkg::*;

  localparam int unsigned POS_W = $clog2(DATA_WIDTH);
  localparam int unsigned LEN_W = POS_W + 1;

  // Input register
  logic                  in_full;
  logic [2:0]            in_opcode;
  logic                  in_qp;
  logic [DATA_WIDTH-1:0] in_a;
  logic                  in_a_nat;
  logic [DATA_WIDTH-1:0] in_b;
  logic                  in_b_nat;
  logic [POS_W-1:0]      in_pos;
  logic [LEN_W-1:0]      in_len;
  logic [IMM_W-1:0]      in_imm;
  logic [DEST_W-1:0]     in_dest;
  logic                  in_peq;

  // Datapath results
  logic [DATA_WIDTH-1:0] exec_value;
  flags_t                exec_flags;

  // Result register
  flags_t                out_flags;

  logic out_load;
  logic in_load;

  // Advance when the next stage is empty or draining
  assign out_load = ~out_valid | ~out_stall;
  assign in_load  = ~in_full | out_load;
  assign in_stall = ~in_load;

  // Hold or capture the incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_load) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      in_opcode <= opcode;
      in_qp     <= qualifying_predicate;
      in_a      <= source_a;
      in_a_nat  <= source_a_nat;
      in_b      <= source_b;
      in_b_nat  <= source_b_nat;
      in_pos    <= bit_position;
      in_len    <= field_length;
      in_imm    <= immediate;
      in_dest   <= dest_index;
      in_peq    <= pred_targets_equal;
    end
  end

  bfdeu_exec #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_exec (
    .opcode               (in_opcode),
    .qualifying_predicate (in_qp),
    .source_a             (in_a),
    .source_a_nat         (in_a_nat),
    .source_b             (in_b),
    .source_b_nat         (in_b_nat),
    .bit_position         (in_pos),
    .field_length         (in_len),
    .immediate            (in_imm),
    .dest_index           (in_dest),
    .pred_targets_equal   (in_peq),
    .result_value         (exec_value),
    .flags                (exec_flags)
  );

  // Hold or capture the finished item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_full) begin
      result_value <= exec_value;
      out_flags    <= exec_flags;
      write_index  <= in_dest;
    end
  end

  assign result_nat       = out_flags.result_nat;
  assign write_register   = out_flags.write_register;
  assign pred_first       = out_flags.pred_first;
  assign pred_second      = out_flags.pred_second;
  assign write_predicates = out_flags.write_predicates;
  assign illegal_fault    = out_flags.illegal_fault;

`include "bit_field_deposit_extract_unit_macros.svh"

  `BFDEU_ASSERT_NOW(a_stall_only_when_full, in_stall, in_full && out_valid && out_stall, "input stall without a full pipeline")
  `BFDEU_ASSERT_NOW(a_one_outcome, out_valid, $onehot0({write_register, write_predicates, illegal_fault}), "more than one outcome on a result item")
  `BFDEU_ASSERT_NOW(a_no_write_zero, out_valid && !write_register, result_value == '0 && !result_nat, "unwritten result carries a value")
  `BFDEU_ASSERT_NOW(a_preds_exclusive, out_valid, !(pred_first && pred_second), "both predicates set")
  `BFDEU_ASSERT_NEXT(a_item_moves_on, in_full && !out_valid, out_valid, "item lost between input and result register")

endmodule

// ----- hw/rtl/bfdeu_exec.sv -----
// Combinational deposit/extract/test-bit datapath for one item.
// Depends on bfdeu_pkg for opcodes and the result flag struct.
module bfdeu_exec #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic [2:0]                      opcode,
  input  logic                            qualifying_predicate,
  input  logic [DATA_WIDTH-1:0]           source_a,
  input  logic                            source_a_nat,
  input  logic [DATA_WIDTH-1:0]           source_b,
  input  logic                            source_b_nat,
  input  logic [$clog2(DATA_WIDTH)-1:0]   bit_position,
  input  logic [$clog2(DATA_WIDTH):0]     field_length,
  input  logic [bfdeu_pkg::IMM_W-1:0]     immediate,
  input  logic [bfdeu_pkg::DEST_W-1:0]    dest_index,
  input  logic                            pred_targets_equal,
  output logic [DATA_WIDTH-1:0]           result_value,
  output bfdeu_pkg::flags_t               flags
);
  import bfdeu_pkg::*;

  localparam int unsigned POS_W = $clog2(DATA_WIDTH);
  localparam int unsigned LEN_W = POS_W + 1;

  logic [LEN_W-1:0]      len_sat;
  logic [LEN_W:0]        len_end;
  logic [LEN_W-1:0]      len_clip;
  logic [LEN_W-1:0]      mask_shift;
  logic [DATA_WIDTH-1:0] mask;
  logic [DATA_WIDTH-1:0] mask_pos;
  logic [DATA_WIDTH-1:0] imm8_ext;
  logic [DATA_WIDTH-1:0] imm1_ext;
  logic                  tested_zero;

  // Saturate the length, then clip the field at the top bit
  always_comb begin
    len_sat = (field_length > LEN_W'(DATA_WIDTH)) ? LEN_W'(DATA_WIDTH) : field_length;
    len_end = {1'b0, len_sat} + (LEN_W+1)'(bit_position);
    len_clip = (len_end > (LEN_W+1)'(DATA_WIDTH))
             ? (LEN_W'(DATA_WIDTH) - LEN_W'(bit_position)) : len_sat;
  end

  // Build the field mask; a zero length shifts every one out
  assign mask_shift = LEN_W'(DATA_WIDTH) - len_clip;
  assign mask       = {DATA_WIDTH{1'b1}} >> mask_shift;
  assign mask_pos   = mask << bit_position;

  // Sign-extend the immediates
  assign imm8_ext = {{(DATA_WIDTH-IMM_W){immediate[IMM_W-1]}}, immediate};
  assign imm1_ext = {DATA_WIDTH{immediate[0]}};

  assign tested_zero = ~source_b[bit_position];

  // Select the operation; anything not written stays zero
  always_comb begin
    result_value = '0;
    flags        = '0;
    if (qualifying_predicate) begin
      unique case (opcode_t'(opcode))
        OP_DEP_REG: begin
          if (dest_index == '0) begin
            flags.illegal_fault = 1'b1;
          end else begin
            result_value = (source_b & ~mask_pos) | ((source_a & mask) << bit_position);
            flags.result_nat     = source_a_nat | source_b_nat;
            flags.write_register = 1'b1;
          end
        end
        OP_EXTR_U: begin
          if (dest_index == '0) begin
            flags.illegal_fault = 1'b1;
          end else begin
            result_value = (source_b >> bit_position) & mask;
            flags.result_nat     = source_b_nat;
            flags.write_register = 1'b1;
          end
        end
        OP_DEP_IMM1: begin
          if (dest_index == '0) begin
            flags.illegal_fault = 1'b1;
          end else begin
            result_value = (source_b & ~mask_pos) | ((imm1_ext & mask) << bit_position);
            flags.result_nat     = source_b_nat;
            flags.write_register = 1'b1;
          end
        end
        OP_ZDEP_IMM: begin
          if (dest_index == '0) begin
            flags.illegal_fault = 1'b1;
          end else begin
            result_value = (imm8_ext & mask) << bit_position;
            flags.write_register = 1'b1;
          end
        end
        OP_TBIT_Z: begin
          if (pred_targets_equal) begin
            flags.illegal_fault = 1'b1;
          end else begin
            // NaT source clears both predicates
            flags.pred_first       = ~source_b_nat & tested_zero;
            flags.pred_second      = ~source_b_nat & ~tested_zero;
            flags.write_predicates = 1'b1;
          end
        end
        default: begin
          flags.illegal_fault = 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking bench for bit_field_deposit_extract_unit: random bursty sender, patterned stall.
// Predicts each result from the accepted item, in order; needs bfdeu_pkg and the unit's RTL.
`timescale 1ns / 100ps

module testbench;
  import bfdeu_pkg::*;

  localparam int unsigned DATA_W      = 64;
  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned REPORT_LIMIT = 10;

  // One instruction as presented on the input channel, plus a drain request
  typedef struct packed {
    logic [2:0]        opcode;
    logic              qp;
    logic [DATA_W-1:0] a;
    logic              a_nat;
    logic [DATA_W-1:0] b;
    logic              b_nat;
    logic [5:0]        pos;
    logic [6:0]        len;
    logic [IMM_W-1:0]  imm;
    logic [DEST_W-1:0] dest;
    logic              peq;
    logic              drain;
  } instr_t;

  // One writeback as seen on the output channel
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              nat;
    logic              wr;
    logic [DEST_W-1:0] idx;
    logic              p1;
    logic              p2;
    logic              wp;
    logic              ill;
  } result_t;

  typedef enum logic [1:0] {PACE_FREE, PACE_LIGHT, PACE_HEAVY, PACE_LONG} pace_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DATA_W-1:0]     result_value;
  logic                  result_nat;
  logic                  write_register;
  logic [DEST_W-1:0]     write_index;
  logic                  pred_first;
  logic                  pred_second;
  logic                  write_predicates;
  logic                  illegal_fault;

  instr_t      cur_item = '0;
  instr_t      pending_items[$];
  result_t     expected_writebacks[STORE_DEPTH];
  int unsigned accept_count = 0;
  int unsigned recv_count = 0;
  int unsigned total_items = 0;
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned reg_writes = 0;
  int unsigned pred_writes = 0;
  int unsigned fault_count = 0;
  int unsigned quiet_count = 0;

  pace_t       stall_mode = PACE_FREE;
  int unsigned mode_left = 0;
  int unsigned stall_run = 0;

  bit_field_deposit_extract_unit #(.DATA_WIDTH(DATA_W)) uut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .opcode              (cur_item.opcode),
    .qualifying_predicate(cur_item.qp),
    .source_a            (cur_item.a),
    .source_a_nat        (cur_item.a_nat),
    .source_b            (cur_item.b),
    .source_b_nat        (cur_item.b_nat),
    .bit_position        (cur_item.pos),
    .field_length        (cur_item.len),
    .immediate           (cur_item.imm),
    .dest_index          (cur_item.dest),
    .pred_targets_equal  (cur_item.peq),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .result_value        (result_value),
    .result_nat          (result_nat),
    .write_register      (write_register),
    .write_index         (write_index),
    .pred_first          (pred_first),
    .pred_second         (pred_second),
    .write_predicates    (write_predicates),
    .illegal_fault       (illegal_fault)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out the writeback of one instruction
  function automatic result_t predict_writeback(instr_t it);
    result_t     r;
    int unsigned span;
    logic [DATA_W-1:0] fmask;
    logic [DATA_W-1:0] imm8_x;
    logic [DATA_W-1:0] imm1_x;
    r = '0;
    r.idx = it.dest;
    // Saturate the length, then clip the field at bit 63
    span = (it.len > DATA_W) ? DATA_W : it.len;
    if (it.pos + span > DATA_W) span = DATA_W - it.pos;
    if (span == 0) fmask = '0;
    else if (span >= DATA_W) fmask = '1;
    else fmask = (64'd1 << span) - 64'd1;
    imm8_x = {{(DATA_W - IMM_W){it.imm[IMM_W-1]}}, it.imm};
    imm1_x = {DATA_W{it.imm[0]}};
    if (it.qp) begin
      if (it.opcode <= OP_ZDEP_IMM && it.dest == '0) begin
        r.ill = 1'b1;
      end else begin
        case (it.opcode)
          OP_DEP_REG: begin
            r.value = (it.b & ~(fmask << it.pos)) | ((it.a & fmask) << it.pos);
            r.nat = it.a_nat | it.b_nat;
            r.wr = 1'b1;
          end
          OP_EXTR_U: begin
            r.value = (it.b >> it.pos) & fmask;
            r.nat = it.b_nat;
            r.wr = 1'b1;
          end
          OP_DEP_IMM1: begin
            r.value = (it.b & ~(fmask << it.pos)) | ((imm1_x & fmask) << it.pos);
            r.nat = it.b_nat;
            r.wr = 1'b1;
          end
          OP_ZDEP_IMM: begin
            r.value = (imm8_x & fmask) << it.pos;
            r.wr = 1'b1;
          end
          OP_TBIT_Z: begin
            if (it.peq) begin
              r.ill = 1'b1;
            end else begin
              // A NaT source clears both predicates
              r.p1 = ~it.b_nat & ~it.b[it.pos];
              r.p2 = ~it.b_nat & it.b[it.pos];
              r.wp = 1'b1;
            end
          end
          default: r.ill = 1'b1;
        endcase
      end
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] random_word();
    logic [DATA_W-1:0] w;
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = '1;
      2: w = 64'd1 << $urandom_range(0, 63);
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // Mostly well-formed instructions with some faults and suppressed ones mixed in
  function automatic instr_t random_instr();
    instr_t it;
    it.opcode = ($urandom_range(0, 99) < 94) ? 3'($urandom_range(0, 4))
                                             : 3'($urandom_range(5, 7));
    it.qp    = ($urandom_range(0, 9) != 0);
    it.a     = random_word();
    it.a_nat = ($urandom_range(0, 7) == 0);
    it.b     = random_word();
    it.b_nat = ($urandom_range(0, 7) == 0);
    it.pos   = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 3))
      0: it.len = 7'($urandom_range(1, 16));
      1: it.len = 7'($urandom_range(1, 64));
      2: it.len = 7'($urandom_range(0, 127));
      default: begin
        case ($urandom_range(0, 5))
          0: it.len = 7'd0;
          1: it.len = 7'd1;
          2: it.len = 7'(64 - it.pos);
          3: it.len = 7'd64;
          4: it.len = 7'd65;
          default: it.len = 7'd127;
        endcase
      end
    endcase
    it.imm   = 8'($urandom_range(0, 255));
    it.dest  = ($urandom_range(0, 15) == 0) ? '0 : 7'($urandom_range(1, 127));
    it.peq   = ($urandom_range(0, 11) == 0);
    it.drain = 1'b0;
    return it;
  endfunction

  // A legal, unsuppressed instruction of one operation, random content
  function automatic instr_t legal_instr(logic [2:0] op);
    instr_t it;
    it = random_instr();
    it.opcode = op;
    it.qp = 1'b1;
    it.dest = 7'($urandom_range(1, 127));
    it.peq = 1'b0;
    return it;
  endfunction

  // Fill the item queue: directed corners first, then the random body
  initial begin
    instr_t it;
    it = legal_instr(OP_DEP_REG);  it.pos = 6'd0;  it.len = 7'd16; it.a_nat = 1'b1;
    pending_items.push_back(it);
    it = legal_instr(OP_DEP_REG);  it.pos = 6'd60; it.len = 7'd16; it.dest = 7'd127;
    pending_items.push_back(it);
    it = legal_instr(OP_DEP_REG);  it.pos = 6'd0;  it.len = 7'd127; it.a = '1; it.b = '0;
    pending_items.push_back(it);
    it = legal_instr(OP_EXTR_U);   it.pos = 6'd63; it.len = 7'd1;  it.b = '1;
    pending_items.push_back(it);
    it = legal_instr(OP_EXTR_U);   it.pos = 6'd0;  it.len = 7'd64; it.b_nat = 1'b1;
    pending_items.push_back(it);
    it = legal_instr(OP_EXTR_U);   it.len = 7'd0;
    pending_items.push_back(it);
    it = legal_instr(OP_DEP_IMM1); it.pos = 6'd5;  it.len = 7'd10; it.imm = 8'hFF; it.b = '0;
    pending_items.push_back(it);
    it = legal_instr(OP_DEP_IMM1); it.pos = 6'd32; it.len = 7'd64; it.imm = 8'hFE; it.b = '1;
    pending_items.push_back(it);
    it = legal_instr(OP_ZDEP_IMM); it.pos = 6'd56; it.len = 7'd8;  it.imm = 8'h80;
    pending_items.push_back(it);
    it = legal_instr(OP_ZDEP_IMM); it.pos = 6'd0;  it.len = 7'd64; it.imm = 8'h7F;
    pending_items.push_back(it);
    it = legal_instr(OP_ZDEP_IMM); it.pos = 6'd63; it.len = 7'd127; it.imm = 8'h80;
    pending_items.push_back(it);
    it = legal_instr(OP_TBIT_Z);   it.pos = 6'd63; it.b = 64'h7FFF_FFFF_FFFF_FFFF;
    it.b_nat = 1'b0; it.dest = '0;
    pending_items.push_back(it);
    it = legal_instr(OP_TBIT_Z);   it.pos = 6'd0;  it.b = 64'd1; it.b_nat = 1'b0;
    pending_items.push_back(it);
    it = legal_instr(OP_TBIT_Z);   it.b_nat = 1'b1;
    pending_items.push_back(it);
    it = legal_instr(OP_TBIT_Z);   it.peq = 1'b1;
    pending_items.push_back(it);
    it = legal_instr(OP_DEP_REG);  it.dest = '0;
    pending_items.push_back(it);
    it = legal_instr(OP_ZDEP_IMM); it.dest = '0;
    pending_items.push_back(it);
    it = legal_instr(OP_EXTR_U);   it.qp = 1'b0;
    pending_items.push_back(it);
    it = legal_instr(OP_TBIT_Z);   it.qp = 1'b0; it.peq = 1'b1;
    pending_items.push_back(it);
    // Undefined operation codes, then one suppressed by the predicate
    for (int c = int'(OP_TBIT_Z) + 1; c < 8; c++) begin
      it = legal_instr(3'(c));
      pending_items.push_back(it);
    end
    it.qp = 1'b0;
    pending_items.push_back(it);

    // Random body; some items wait for the pipe to drain first
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      it = random_instr();
      it.drain = (n == 0) || ($urandom_range(0, 119) == 0);
      pending_items.push_back(it);
    end
    total_items = pending_items.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to go in, then for the pipe to empty
    wait (accept_count == total_items);
    for (int k = 0; k < 2000 && recv_count != accept_count; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (recv_count != accept_count) begin
      $display("%0d expected results never arrived", accept_count - recv_count);
    end
    $display("checked %0d results from %0d items: %0d register writes, %0d predicate writes,",
             recv_count, accept_count, reg_writes, pred_writes);
    $display("  %0d faults, %0d with nothing written", fault_count, quiet_count);
    if (mismatch_count == 0 && recv_count == accept_count) begin
      $display("bit_field_deposit_extract_unit verification clean");
    end else begin
      $display("bit_field_deposit_extract_unit verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("bit_field_deposit_extract_unit verification failed");
    $finish;
  end

  // Drive items in bursts; hold on stall; record the prediction on acceptance
  always @(posedge clk) begin : drive_items
    instr_t      nxt;
    logic        took;
    int unsigned issued;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= $urandom_range(1, 40);
    end else begin
      took = in_valid && !in_stall;
      issued = accept_count;
      if (took) begin
        expected_writebacks[accept_count % STORE_DEPTH] = predict_writeback(cur_item);
        issued = accept_count + 1;
        accept_count <= issued;
      end
      if (!in_valid || took) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0 ||
                     (pending_items[0].drain && issued != recv_count)) begin
          in_valid <= 1'b0;
        end else begin
          nxt = pending_items.pop_front();
          cur_item <= nxt;
          in_valid <= 1'b1;
          // Start a new burst: mostly short, now and then a long stretch with no gaps
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
            gap_left <= $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Stall the output on a changing pattern
  always @(posedge clk) begin : pace_receiver
    if (rst) begin
      out_stall <= 1'b0;
      stall_mode <= PACE_FREE;
      mode_left <= 100;
      stall_run <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= pace_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(32, 256);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        PACE_FREE:  out_stall <= 1'b0;
        PACE_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        PACE_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_run != 0) begin
            stall_run <= stall_run - 1;
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 7) == 0) stall_run <= $urandom_range(5, 20);
          end
        end
      endcase
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    result_t seen;
    result_t want;
    string   diffs;
    if (!rst && out_valid && !out_stall) begin
      seen.value = result_value;
      seen.nat   = result_nat;
      seen.wr    = write_register;
      seen.idx   = write_index;
      seen.p1    = pred_first;
      seen.p2    = pred_second;
      seen.wp    = write_predicates;
      seen.ill   = illegal_fault;
      if (recv_count >= accept_count) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("result with nothing expected: value=%h idx=%0d", seen.value, seen.idx);
        end
      end else begin
        want = expected_writebacks[recv_count % STORE_DEPTH];
        recv_count <= recv_count + 1;
        if (seen.wr) reg_writes++;
        if (seen.wp) pred_writes++;
        if (seen.ill) fault_count++;
        if (!seen.wr && !seen.wp && !seen.ill) quiet_count++;
        diffs = "";
        if (seen.value !== want.value) diffs = {diffs, " value"};
        if (seen.nat !== want.nat) diffs = {diffs, " nat"};
        if (seen.wr !== want.wr) diffs = {diffs, " write_register"};
        if (seen.idx !== want.idx) diffs = {diffs, " write_index"};
        if (seen.p1 !== want.p1) diffs = {diffs, " pred_first"};
        if (seen.p2 !== want.p2) diffs = {diffs, " pred_second"};
        if (seen.wp !== want.wp) diffs = {diffs, " write_predicates"};
        if (seen.ill !== want.ill) diffs = {diffs, " illegal_fault"};
        if (diffs != "") begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("result %0d differs in%s", recv_count, diffs);
            $display("  expected value=%h nat=%b wr=%b idx=%0d p=%b%b wp=%b ill=%b",
                     want.value, want.nat, want.wr, want.idx, want.p1, want.p2,
                     want.wp, want.ill);
            $display("  actual   value=%h nat=%b wr=%b idx=%0d p=%b%b wp=%b ill=%b",
                     seen.value, seen.nat, seen.wr, seen.idx, seen.p1, seen.p2,
                     seen.wp, seen.ill);
          end
        end
      end
    end
  end

endmodule
